// ===== src/c3e_pkg.sv =====
// Package for the 3x3 clamped-edge convolution block: widths, register and
// kernel codes, the coefficient table and the shared arithmetic helpers.
// Depends on nothing; every other file of the block imports it.
package c3e_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_HEIGHT       = 4096;

    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 12;
    localparam int NC_W        = 3;
    localparam int CHAN_W      = 2;
    localparam int KSEL_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam int FIFO_DEPTH = 16;

    localparam int COEF_W   = 20;
    localparam int PROD_W   = 29;
    localparam int ROWSUM_W = 31;
    localparam int SUM_W    = 33;
    localparam int ONE_Q    = 65536;
    localparam int TAPS     = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SELECT = 2'd3;

    localparam logic [KSEL_W-1:0] KSEL_EDGE     = 3'd0;
    localparam logic [KSEL_W-1:0] KSEL_SHARPEN  = 3'd1;
    localparam logic [KSEL_W-1:0] KSEL_BOX      = 3'd2;
    localparam logic [KSEL_W-1:0] KSEL_GAUSSIAN = 3'd3;
    localparam logic [KSEL_W-1:0] KSEL_EMBOSS   = 3'd4;
    localparam logic [KSEL_W-1:0] KSEL_IDENTITY = 3'd5;
    localparam int KERNEL_COUNT = 6;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ROWSUM_W-1:0] rowsum_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // One window column, entry 0 is the top row.
    typedef logic [2:0][7:0] col_t;
    // Nine filter taps, entry row*3+col.
    typedef logic [TAPS-1:0][7:0] taps_t;

    typedef struct packed {
        col_t prev_col;
        col_t cur_col;
    } win_t;

    // Control of one request as it leaves the counters.
    typedef struct packed {
        logic              drain;
        logic [7:0]        sample;
        logic [CHAN_W-1:0] chan;
        logic              top_mid;
        logic              has_a;
        logic              has_b;
        logic              a_wide;
        logic              b_narrow;
        logic              eof;
    } item_t;

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic eof;
    } flags_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       eof;
    } res_t;

    localparam coef_t KERNEL_TABLE [KERNEL_COUNT][TAPS] = '{
        '{coef_t'(0), coef_t'(-ONE_Q), coef_t'(0),
          coef_t'(-ONE_Q), coef_t'(4 * ONE_Q), coef_t'(-ONE_Q),
          coef_t'(0), coef_t'(-ONE_Q), coef_t'(0)},
        '{coef_t'(0), coef_t'(-ONE_Q), coef_t'(0),
          coef_t'(-ONE_Q), coef_t'(5 * ONE_Q), coef_t'(-ONE_Q),
          coef_t'(0), coef_t'(-ONE_Q), coef_t'(0)},
        '{coef_t'(7282), coef_t'(7282), coef_t'(7282),
          coef_t'(7282), coef_t'(7282), coef_t'(7282),
          coef_t'(7282), coef_t'(7282), coef_t'(7282)},
        '{coef_t'(4096), coef_t'(8192), coef_t'(4096),
          coef_t'(8192), coef_t'(16384), coef_t'(8192),
          coef_t'(4096), coef_t'(8192), coef_t'(4096)},
        '{coef_t'(-2 * ONE_Q), coef_t'(-ONE_Q), coef_t'(0),
          coef_t'(-ONE_Q), coef_t'(ONE_Q), coef_t'(ONE_Q),
          coef_t'(0), coef_t'(ONE_Q), coef_t'(2 * ONE_Q)},
        '{coef_t'(0), coef_t'(0), coef_t'(0),
          coef_t'(0), coef_t'(ONE_Q), coef_t'(0),
          coef_t'(0), coef_t'(0), coef_t'(0)}
    };

    // Selections beyond the last kernel behave as identity.
    function automatic coef_t kernel_coef(input logic [KSEL_W-1:0] ksel, input int tap);
        logic [KSEL_W-1:0] k;
        k = (ksel > KSEL_IDENTITY) ? KSEL_IDENTITY : ksel;
        return KERNEL_TABLE[k][tap];
    endfunction

    function automatic prod_t tap_product(input logic [7:0] px, input coef_t co);
        logic signed [8:0] pxs;
        prod_t             p;
        pxs = signed'({1'b0, px});
        p   = pxs * co;
        return p;
    endfunction

    // A non-positive sum gives zero, otherwise the integer part saturated to 255.
    function automatic logic [7:0] saturate(input sum_t s);
        logic [7:0] r;
        if (s <= sum_t'(0)) begin
            r = 8'd0;
        end else if (s[SUM_W-1:16] > (SUM_W - 16)'(255)) begin
            r = 8'd255;
        end else begin
            r = s[23:16];
        end
        return r;
    endfunction

endpackage

// ===== src/c3e_ctrl.sv =====
// Configuration registers, raster position counters and output credit for
// the convolution block; decides per request what the pipeline produces.
// Depends on c3e_pkg.
module c3e_ctrl import c3e_pkg::*; #(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int LineAw      = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [7:0]             s_sample,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   pop,
    output logic                   launch,
    output item_t                  item,
    output logic [LineAw-1:0]      idx,
    output logic [KSEL_W-1:0]      kernel_sel
);

    localparam int ColW  = $clog2(MAX_WIDTH);
    localparam int WEffW = $clog2(MAX_WIDTH + 1);
    localparam int ResW  = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH_CFG_W-1:0] width_cfg_reg;
    logic [HEIGHT_W-1:0]    height_cfg_reg;
    logic [NC_W-1:0]        chans_cfg_reg;
    logic [KSEL_W-1:0]      kernel_reg;

    logic [ColW-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [LineAw-1:0] idx_reg, idx_next;
    logic              draining_reg, draining_next;
    logic [ResW-1:0]   resv_reg, resv_next;

    logic [WEffW-1:0]    w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [NC_W-1:0]     nc_eff;
    logic                last_col, last_ch, last_row, has_out;
    logic [1:0]          n_res;

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WEffW'(1);
        end else if (int'(width_cfg_reg) > MAX_WIDTH) begin
            w_eff = WEffW'(MAX_WIDTH);
        end else begin
            w_eff = WEffW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (int'(height_cfg_reg) > MAX_HEIGHT) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_cfg_reg;
        end
        if (chans_cfg_reg == '0) begin
            nc_eff = NC_W'(1);
        end else if (int'(chans_cfg_reg) > MAX_CHANNELS) begin
            nc_eff = NC_W'(MAX_CHANNELS);
        end else begin
            nc_eff = chans_cfg_reg;
        end
    end

    assign last_col = (WEffW'(col_reg) + WEffW'(1)) >= w_eff;
    assign last_ch  = (NC_W'(chan_reg) + NC_W'(1)) >= nc_eff;
    assign last_row = (HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= h_eff;
    assign has_out  = s_func || (row_reg != '0);

    always_comb begin
        item.drain    = s_func;
        item.sample   = s_sample;
        item.chan     = chan_reg;
        item.top_mid  = s_func ? (row_reg == '0) : (row_reg <= ROW_W'(1));
        item.has_a    = has_out && (col_reg != '0);
        item.has_b    = has_out && last_col;
        item.a_wide   = col_reg == ColW'(1);
        item.b_narrow = col_reg == '0;
        item.eof      = s_func && last_col && last_ch;
    end

    assign s_ready    = resv_reg <= ResW'(FIFO_DEPTH - 2);
    assign launch     = s_valid && s_ready && (s_func == draining_reg);
    assign idx        = idx_reg;
    assign kernel_sel = kernel_reg;
    assign n_res      = {1'b0, item.has_a} + {1'b0, item.has_b};

    always_comb begin
        resv_next = resv_reg + (launch ? ResW'(n_res) : ResW'(0))
                    - (pop ? ResW'(1) : ResW'(0));
        col_next      = col_reg;
        row_next      = row_reg;
        chan_next     = chan_reg;
        idx_next      = idx_reg;
        draining_next = draining_reg;
        if (cfg_wr_en) begin
            col_next      = '0;
            row_next      = '0;
            chan_next     = '0;
            idx_next      = '0;
            draining_next = 1'b0;
        end else if (launch) begin
            if (!last_ch) begin
                chan_next = chan_reg + CHAN_W'(1);
                idx_next  = idx_reg + LineAw'(1);
            end else begin
                chan_next = '0;
                if (!last_col) begin
                    col_next = col_reg + ColW'(1);
                    idx_next = idx_reg + LineAw'(1);
                end else begin
                    col_next = '0;
                    idx_next = '0;
                    if (s_func) begin
                        row_next      = '0;
                        draining_next = 1'b0;
                    end else if (last_row) begin
                        draining_next = 1'b1;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_CFG_W'(1);
            height_cfg_reg <= HEIGHT_W'(1);
            chans_cfg_reg  <= NC_W'(1);
            kernel_reg     <= KSEL_IDENTITY;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_cfg_reg  <= cfg_wr_data[WIDTH_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_cfg_reg <= cfg_wr_data[HEIGHT_W-1:0];
                CFG_CHANNEL_COUNT: chans_cfg_reg  <= cfg_wr_data[NC_W-1:0];
                CFG_KERNEL_SELECT: kernel_reg     <= cfg_wr_data[KSEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            chan_reg     <= '0;
            idx_reg      <= '0;
            draining_reg <= 1'b0;
            resv_reg     <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            chan_reg     <= chan_next;
            idx_reg      <= idx_next;
            draining_reg <= draining_next;
            resv_reg     <= resv_next;
        end
    end

endmodule

// ===== src/c3e_line_buf.sv =====
// The two line memories with registered reads, their write-back and the
// forwarding that covers a read of the entry written in the same cycle.
// Depends on c3e_pkg.
module c3e_line_buf import c3e_pkg::*; #(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int LineAw      = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              launch,
    input  item_t             item,
    input  logic [LineAw-1:0] idx,
    output logic              s1_valid,
    output item_t             s1_item,
    output logic [7:0]        top,
    output logic [7:0]        mid,
    output logic [7:0]        bot
);

    localparam int LineDepth = MAX_WIDTH * MAX_CHANNELS;

    logic [7:0] older_mem_reg [LineDepth];
    logic [7:0] newer_mem_reg [LineDepth];

    logic [7:0]        older_q_reg, newer_q_reg;
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [LineAw-1:0] s1_idx_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_older_reg, fwd_newer_reg;
    logic [7:0]        older_rd, newer_rd;
    logic              wr_en;

    assign older_rd = fwd_reg ? fwd_older_reg : older_q_reg;
    assign newer_rd = fwd_reg ? fwd_newer_reg : newer_q_reg;
    assign mid      = newer_rd;
    assign bot      = s1_item_reg.drain ? newer_rd : s1_item_reg.sample;
    assign top      = s1_item_reg.top_mid ? newer_rd : older_rd;
    assign wr_en    = s1_valid_reg && !s1_item_reg.drain;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

    always_ff @(posedge aclk) begin
        if (launch) begin
            older_q_reg <= older_mem_reg[idx];
            newer_q_reg <= newer_mem_reg[idx];
        end
        if (wr_en) begin
            older_mem_reg[s1_idx_reg] <= mid;
            newer_mem_reg[s1_idx_reg] <= bot;
        end
    end

    // A request that reads the entry being written this cycle takes the new data.
    always_ff @(posedge aclk) begin
        if (launch) begin
            s1_item_reg   <= item;
            s1_idx_reg    <= idx;
            fwd_older_reg <= mid;
            fwd_newer_reg <= bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= launch;
            if (launch) begin
                fwd_reg <= wr_en && (s1_idx_reg == idx);
            end
        end
    end

endmodule

// ===== src/c3e_window.sv =====
// Per-channel window columns: shifts in the new column of each request and
// registers the taps of the two possible results. Depends on c3e_pkg.
// Any configuration write or the end of a frame clears every window.
module c3e_window import c3e_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_clear,
    input  logic       s1_valid,
    input  item_t      s1_item,
    input  logic [7:0] top,
    input  logic [7:0] mid,
    input  logic [7:0] bot,
    output logic       s2_valid,
    output flags_t     s2_flags,
    output taps_t      s2_taps_a,
    output taps_t      s2_taps_b
);

    localparam int KW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    win_t   window_reg [MAX_CHANNELS];
    win_t   old_win, upd_win;
    col_t   cur, n0, n1, n2;
    taps_t  taps_a, taps_b;
    logic   s2_valid_reg;
    flags_t s2_flags_reg;
    taps_t  s2_taps_a_reg, s2_taps_b_reg;

    always_comb begin
        old_win          = window_reg[s1_item.chan[KW-1:0]];
        cur[0]           = top;
        cur[1]           = mid;
        cur[2]           = bot;
        n0               = old_win.prev_col;
        n1               = old_win.cur_col;
        n2               = cur;
        upd_win.prev_col = n1;
        upd_win.cur_col  = n2;
        for (int r = 0; r < 3; r++) begin
            taps_a[r*3]     = s1_item.a_wide ? n1[r] : n0[r];
            taps_a[r*3 + 1] = n1[r];
            taps_a[r*3 + 2] = n2[r];
            taps_b[r*3]     = s1_item.b_narrow ? n2[r] : n1[r];
            taps_b[r*3 + 1] = n2[r];
            taps_b[r*3 + 2] = n2[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear || (s1_valid && s1_item.eof)) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                window_reg[i] <= '0;
            end
        end else if (s1_valid) begin
            window_reg[s1_item.chan[KW-1:0]] <= upd_win;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid) begin
            s2_flags_reg.has_a <= s1_item.has_a;
            s2_flags_reg.has_b <= s1_item.has_b;
            s2_flags_reg.eof   <= s1_item.eof;
            s2_taps_a_reg      <= taps_a;
            s2_taps_b_reg      <= taps_b;
        end
    end

    assign s2_valid  = s2_valid_reg;
    assign s2_flags  = s2_flags_reg;
    assign s2_taps_a = s2_taps_a_reg;
    assign s2_taps_b = s2_taps_b_reg;

endmodule

// ===== src/c3e_filter.sv =====
// Kernel arithmetic: registered tap products, registered row sums, then the
// final sum with truncation and saturation for both results of a request.
// Depends on c3e_pkg.
module c3e_filter import c3e_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [KSEL_W-1:0] kernel_sel,
    input  logic              s2_valid,
    input  flags_t            s2_flags,
    input  taps_t             s2_taps_a,
    input  taps_t             s2_taps_b,
    output logic              wr_a,
    output res_t              res_a,
    output logic              wr_b,
    output res_t              res_b
);

    logic    s3_valid_reg, s4_valid_reg;
    flags_t  s3_flags_reg, s4_flags_reg;
    prod_t   prod_a_reg [TAPS];
    prod_t   prod_b_reg [TAPS];
    rowsum_t rsum_a_reg [3];
    rowsum_t rsum_b_reg [3];
    sum_t    total_a, total_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid) begin
            s3_flags_reg <= s2_flags;
            for (int i = 0; i < TAPS; i++) begin
                prod_a_reg[i] <= tap_product(s2_taps_a[i], kernel_coef(kernel_sel, i));
                prod_b_reg[i] <= tap_product(s2_taps_b[i], kernel_coef(kernel_sel, i));
            end
        end
        if (s3_valid_reg) begin
            s4_flags_reg <= s3_flags_reg;
            for (int r = 0; r < 3; r++) begin
                rsum_a_reg[r] <= ROWSUM_W'(prod_a_reg[r*3]) + ROWSUM_W'(prod_a_reg[r*3 + 1])
                                 + ROWSUM_W'(prod_a_reg[r*3 + 2]);
                rsum_b_reg[r] <= ROWSUM_W'(prod_b_reg[r*3]) + ROWSUM_W'(prod_b_reg[r*3 + 1])
                                 + ROWSUM_W'(prod_b_reg[r*3 + 2]);
            end
        end
    end

    always_comb begin
        total_a = SUM_W'(rsum_a_reg[0]) + SUM_W'(rsum_a_reg[1]) + SUM_W'(rsum_a_reg[2]);
        total_b = SUM_W'(rsum_b_reg[0]) + SUM_W'(rsum_b_reg[1]) + SUM_W'(rsum_b_reg[2]);
        wr_a        = s4_valid_reg && s4_flags_reg.has_a;
        res_a.pixel = saturate(total_a);
        res_a.last  = !s4_flags_reg.has_b;
        res_a.eof   = 1'b0;
        wr_b        = s4_valid_reg && s4_flags_reg.has_b;
        res_b.pixel = saturate(total_b);
        res_b.last  = 1'b1;
        res_b.eof   = s4_flags_reg.eof;
    end

endmodule

// ===== src/c3e_out_fifo.sv =====
// Result queue in front of the output port; takes up to two results a cycle
// and gives one. Room is reserved upstream, so it never overflows.
// Depends on c3e_pkg.
module c3e_out_fifo import c3e_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_a,
    input  res_t res_a,
    input  logic wr_b,
    input  res_t res_b,
    output logic m_valid,
    input  logic m_ready,
    output res_t head
);

    localparam int PtrW = $clog2(FIFO_DEPTH);
    localparam int CntW = $clog2(FIFO_DEPTH + 1);

    res_t            fifo_reg [FIFO_DEPTH];
    logic [PtrW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            pop;
    logic [1:0]      n_wr;

    assign m_valid = cnt_reg != '0;
    assign head    = fifo_reg[rp_reg];
    assign pop     = m_valid && m_ready;
    assign n_wr    = {1'b0, wr_a} + {1'b0, wr_b};

    always_comb begin
        wp_next  = wp_reg + PtrW'(n_wr);
        rp_next  = rp_reg + (pop ? PtrW'(1) : PtrW'(0));
        cnt_next = cnt_reg + CntW'(n_wr) - (pop ? CntW'(1) : CntW'(0));
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            fifo_reg[wp_reg] <= res_a;
        end
        if (wr_b) begin
            fifo_reg[wr_a ? wp_reg + PtrW'(1) : wp_reg] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/conv3x3_clamped_edge.sv =====
// Top level of the streaming 3x3 convolution with clamped image edges.
// Depends on c3e_pkg, c3e_ctrl, c3e_line_buf, c3e_window, c3e_filter, c3e_out_fifo.
//
// The block takes one channel sample per clock while s_ready is high, in raster,
// channel-interleaved order, and filters each channel with the selected 3x3 kernel;
// the result for pixel (x,y) comes from the request that takes sample (x+1,y+1), and
// the last column of a row gives a second result from the same request. Two line
// memories of MAX_WIDTH*MAX_CHANNELS bytes are read once per request and written
// once per non-drain request, so a request can enter every cycle; the output side
// delivers one result per cycle while m_ready is high, and s_ready falls only when the
// 16-entry result queue, counting results still in the pipeline, could not take two
// more. After the last row, one drain request per channel sample of a row brings out
// the final row. Line memories need no clearing pass after reset. Any configuration
// write restarts the frame and must be issued while the block is idle.
module conv3x3_clamped_edge import c3e_pkg::*; #(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [7:0]             s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_pixel_out,
    output logic                   m_last_of_run,
    output logic                   m_end_of_frame,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int LineAw = $clog2(MAX_WIDTH * MAX_CHANNELS);

    logic              launch, s1_valid, s2_valid, wr_a, wr_b, pop;
    item_t             item, s1_item;
    logic [LineAw-1:0] idx;
    logic [KSEL_W-1:0] kernel_sel;
    logic [7:0]        top, mid, bot;
    flags_t            s2_flags;
    taps_t             s2_taps_a, s2_taps_b;
    res_t              res_a, res_b, head;

    assign pop = m_valid && m_ready;

    c3e_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_sample    (s_sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .pop         (pop),
        .launch      (launch),
        .item        (item),
        .idx         (idx),
        .kernel_sel  (kernel_sel)
    );

    c3e_line_buf #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .launch   (launch),
        .item     (item),
        .idx      (idx),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .top      (top),
        .mid      (mid),
        .bot      (bot)
    );

    c3e_window #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_clear (cfg_wr_en),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .top       (top),
        .mid       (mid),
        .bot       (bot),
        .s2_valid  (s2_valid),
        .s2_flags  (s2_flags),
        .s2_taps_a (s2_taps_a),
        .s2_taps_b (s2_taps_b)
    );

    c3e_filter u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .kernel_sel (kernel_sel),
        .s2_valid   (s2_valid),
        .s2_flags   (s2_flags),
        .s2_taps_a  (s2_taps_a),
        .s2_taps_b  (s2_taps_b),
        .wr_a       (wr_a),
        .res_a      (res_a),
        .wr_b       (wr_b),
        .res_b      (res_b)
    );

    c3e_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_a    (wr_a),
        .res_a   (res_a),
        .wr_b    (wr_b),
        .res_b   (res_b),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_pixel_out    = head.pixel;
    assign m_last_of_run  = head.last;
    assign m_end_of_frame = head.eof;

endmodule
